>>> design/tsdc_pkg.sv
// Shared constants for the triangle sum-set / difference-set comparator.
// Holds the fixed field widths of the stream payloads and the config register.
// No dependencies.
package tsdc_pkg;

    // input payload: point membership mask
    localparam int MASK_W    = 55;
    localparam int IN_DATA_W = 56;

    // result payload: sum count, difference count, more-sums flag
    localparam int CNT_W      = 9;
    localparam int OUT_DATA_W = 24;

    // row-count register
    localparam int CFG_W      = 4;
    localparam int ROWS_RESET = 10;

    // rows added together in one adder group of the count tree
    localparam int GRP = 5;

endpackage

>>> design/triangle_sumset_diffset_compare_core.sv
// Triangle sum-set / difference-set comparator, fully pipelined.
// Depends on tsdc_pkg for payload widths and the config reset value.
//
// Usage:
//   Slave stream (i_s_axis_*) carries one request per beat: tdata[54:0] is
//   the membership mask over the triangular lattice in row-major order.
//   Master stream (o_m_axis_*) returns one result per request, in order:
//   tdata[8:0] distinct sums, tdata[17:9] distinct differences, tdata[18]
//   set when sums outnumber differences.
//   i_cfg_we / i_cfg_wdata set the number of rows (values above MAX_ROWS act
//   as MAX_ROWS, zero gives an empty lattice). Write it only while idle.
// Pipeline:
//   A request goes from the accepting edge to tvalid through row gating into
//   the input register, pair marking over the sum and difference grids,
//   per-row population counts, two adder levels, and the compare in the
//   output register. One request is accepted every cycle unless the output
//   stalls; throughput is set by the six-stage pipeline, one beat per clock.
// Reset and stall:
//   Reset empties the pipeline and sets the row count to 10. When the
//   receiver holds tready low with a result waiting, every stage holds and
//   tready on the slave side drops; nothing is lost or repeated.
module triangle_sumset_diffset_compare_core
    import tsdc_pkg::*;
#(
    parameter int MAX_ROWS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [54:0] point_mask
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata    // [8:0] sum_count,
                                                    // [17:9] diff_count,
                                                    // [18] more_sums
);

    localparam int SIDE = 2 * MAX_ROWS - 1;
    localparam int RC_W = $clog2(SIDE + 1);
    localparam int NGRP = (SIDE + GRP - 1) / GRP;

    typedef logic [MAX_ROWS-1:0] t_pts [MAX_ROWS];
    typedef logic [SIDE-1:0]     t_grid [SIDE];

    // pipeline control
    logic       adv;
    logic [4:0] r_vld;
    logic       r_out_vld;

    // payload registers and next values
    logic [CFG_W-1:0]      r_rows;
    logic [CFG_W-1:0]      rows_eff;
    t_pts                  n_pts,  r_pts;
    t_grid                 n_sum,  r_sum;
    t_grid                 n_dif,  r_dif;
    logic [RC_W-1:0]       n_sum_rc [SIDE];
    logic [RC_W-1:0]       n_dif_rc [SIDE];
    logic [RC_W-1:0]       r_sum_rc [SIDE];
    logic [RC_W-1:0]       r_dif_rc [SIDE];
    logic [CNT_W-1:0]      n_sum_g  [NGRP];
    logic [CNT_W-1:0]      n_dif_g  [NGRP];
    logic [CNT_W-1:0]      r_sum_g  [NGRP];
    logic [CNT_W-1:0]      r_dif_g  [NGRP];
    logic [CNT_W-1:0]      n_sum_tot, r_sum_tot;
    logic [CNT_W-1:0]      n_dif_tot, r_dif_tot;
    logic [OUT_DATA_W-1:0] n_out, r_out;

    // advance the whole pipe unless a result is stuck at the output
    assign adv             = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    // row-count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(ROWS_RESET);
        end else if (i_cfg_we) begin
            r_rows <= i_cfg_wdata;
        end
    end

    // saturate the row count to the lattice size
    assign rows_eff = (r_rows > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : r_rows;

    // stage 1: unpack the mask into rows, drop rows beyond the lattice
    always_comb begin
        n_pts = '{default: '0};
        for (int r = 0; r < MAX_ROWS; r++) begin
            for (int c = 0; c <= r; c++) begin
                n_pts[r][c] = i_s_axis_tdata[((r * (r + 1)) >> 1) + c]
                              & (CFG_W'(r) < rows_eff);
            end
        end
    end

    // stage 2: mark every pairwise sum and difference
    always_comb begin
        n_sum = '{default: '0};
        n_dif = '{default: '0};
        for (int ra = 0; ra < MAX_ROWS; ra++) begin
            for (int ca = 0; ca <= ra; ca++) begin
                for (int rb = 0; rb < MAX_ROWS; rb++) begin
                    for (int cb = 0; cb <= rb; cb++) begin
                        n_sum[ra + rb][ca + cb] = n_sum[ra + rb][ca + cb]
                            | (r_pts[ra][ca] & r_pts[rb][cb]);
                        n_dif[ra - rb + MAX_ROWS - 1][ca - cb + MAX_ROWS - 1] =
                            n_dif[ra - rb + MAX_ROWS - 1][ca - cb + MAX_ROWS - 1]
                            | (r_pts[ra][ca] & r_pts[rb][cb]);
                    end
                end
            end
        end
    end

    // stage 3: population count of each grid row
    always_comb begin
        for (int k = 0; k < SIDE; k++) begin
            n_sum_rc[k] = RC_W'($countones(r_sum[k]));
            n_dif_rc[k] = RC_W'($countones(r_dif[k]));
        end
    end

    // stage 4: add row counts in small groups
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_sum_g[g] = '0;
            n_dif_g[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < SIDE) begin
                    n_sum_g[g] = n_sum_g[g] + CNT_W'(r_sum_rc[g * GRP + k]);
                    n_dif_g[g] = n_dif_g[g] + CNT_W'(r_dif_rc[g * GRP + k]);
                end
            end
        end
    end

    // stage 5: add the group sums into the totals
    always_comb begin
        n_sum_tot = '0;
        n_dif_tot = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_sum_tot = n_sum_tot + r_sum_g[g];
            n_dif_tot = n_dif_tot + r_dif_g[g];
        end
    end

    // output stage: compare and pack the result
    always_comb begin
        n_out = '0;
        n_out[CNT_W-1:0]         = r_sum_tot;
        n_out[2*CNT_W-1:CNT_W]   = r_dif_tot;
        n_out[2*CNT_W]           = (r_sum_tot > r_dif_tot);
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[3:0], i_s_axis_tvalid};
            r_out_vld <= r_vld[4];
        end
    end

    // payload registers hold while stalled
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pts     <= n_pts;
            r_sum     <= n_sum;
            r_dif     <= n_dif;
            r_sum_rc  <= n_sum_rc;
            r_dif_rc  <= n_dif_rc;
            r_sum_g   <= n_sum_g;
            r_dif_g   <= n_dif_g;
            r_sum_tot <= n_sum_tot;
            r_dif_tot <= n_dif_tot;
            r_out     <= n_out;
        end
    end

    // a non-empty difference set holds zero and pairs of opposites: odd size
    a_dif_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out[2*CNT_W-1:CNT_W] != '0)) |-> r_out[CNT_W])
        else $error("difference count is even and nonzero");

    // sums and differences are empty together
    a_empty_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out[CNT_W-1:0] == '0) == (r_out[2*CNT_W-1:CNT_W] == '0)))
        else $error("only one of sum and difference sets is empty");

    // a stalled output freezes the whole pipe
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_axis_tready) |=> ($stable(r_vld) && r_out_vld))
        else $error("pipeline moved while output stalled");

endmodule
